### hdl/sscc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscc_pkg
// Shared widths, register indexes and word types of the sphere contact core.
// ----------------------------------------------------------------------------
package sscc_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int INDEX_WIDTH    = 16;
   localparam int LEN_WIDTH      = 31;
   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = LEN_WIDTH;

   localparam int MAG_WIDTH      = COORD_WIDTH + 1;
   localparam int HALF_MAG       = (MAG_WIDTH + 1) / 2;
   localparam int THR_WIDTH      = LEN_WIDTH + 2;
   localparam int HALF_THR       = (THR_WIDTH + 1) / 2;
   localparam int SUM_WIDTH      = 2 * MAG_WIDTH;
   localparam int THR_SQ_WIDTH   = 2 * THR_WIDTH;
   localparam int CMP_WIDTH      = (SUM_WIDTH > THR_SQ_WIDTH) ? SUM_WIDTH : THR_SQ_WIDTH;
   localparam int PROD_WIDTH     = LEN_WIDTH + MAG_WIDTH;
   localparam int QUO_WIDTH      = LEN_WIDTH + 1;
   localparam int EXT_WIDTH      = ((COORD_WIDTH > QUO_WIDTH) ? COORD_WIDTH : QUO_WIDTH) + 2;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_MARGIN_A = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_MARGIN_B = 1'd1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] centre_a_x;
      logic signed [COORD_WIDTH-1:0] centre_a_y;
      logic signed [COORD_WIDTH-1:0] centre_a_z;
      logic [LEN_WIDTH-1:0]          radius_a;
      logic                          friction_a;
      logic [INDEX_WIDTH-1:0]        first_index;
      logic signed [COORD_WIDTH-1:0] centre_b_x;
      logic signed [COORD_WIDTH-1:0] centre_b_y;
      logic signed [COORD_WIDTH-1:0] centre_b_z;
      logic [LEN_WIDTH-1:0]          radius_b;
      logic                          friction_b;
      logic [INDEX_WIDTH-1:0]        second_index;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_a_x;
      logic signed [COORD_WIDTH-1:0] point_a_y;
      logic signed [COORD_WIDTH-1:0] point_a_z;
      logic signed [COORD_WIDTH-1:0] point_b_x;
      logic signed [COORD_WIDTH-1:0] point_b_y;
      logic signed [COORD_WIDTH-1:0] point_b_z;
      logic                          separated;
      logic                          friction_on;
      logic [INDEX_WIDTH-1:0]        contact_first_index;
      logic [INDEX_WIDTH-1:0]        contact_second_index;
   } rsp_word_type;

   // carried alongside the square root
   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] ca;
      logic [2:0][COORD_WIDTH-1:0] cb;
      logic [2:0]                  neg;
      logic [2:0][PROD_WIDTH-1:0]  prod_a;
      logic [2:0][PROD_WIDTH-1:0]  prod_b;
      logic                        separated;
      logic                        friction_on;
      logic [INDEX_WIDTH-1:0]      idx_first;
      logic [INDEX_WIDTH-1:0]      idx_second;
   } root_side_type;

   // carried alongside the dividers
   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] ca;
      logic [2:0][COORD_WIDTH-1:0] cb;
      logic [2:0]                  neg;
      logic                        zero;
      logic                        separated;
      logic                        friction_on;
      logic [INDEX_WIDTH-1:0]      idx_first;
      logic [INDEX_WIDTH-1:0]      idx_second;
   } quo_side_type;

endpackage

### hdl/sscc_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscc_delay
// Fixed-length delay line with a valid bit, advancing on enable.
// ----------------------------------------------------------------------------
module sscc_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff[0] <= in_data;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

### hdl/sscc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscc_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module sscc_sqrt #(
   parameter int ROOT_W = sscc_pkg::MAG_WIDTH
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root
);

   localparam int REM_W = ROOT_W + 3;

   logic [2*ROOT_W-1:0] rad_ff  [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [2*ROOT_W-1:0] rad_in  [ROOT_W];
   logic [REM_W-1:0]    rem_in  [ROOT_W];
   logic [ROOT_W-1:0]   root_in [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [2*ROOT_W-1:0] rad_prev;
      logic [REM_W-1:0]    rem_prev;
      logic [ROOT_W-1:0]   root_prev;
      logic [REM_W-1:0]    shifted;
      logic [REM_W-1:0]    trial;
      logic                take;

      if (k == 0) begin : g_first
         assign rad_prev  = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign shifted    = {rem_prev[REM_W-3:0], rad_prev[2*ROOT_W-1 -: 2]};
      assign trial      = REM_W'({root_prev, 2'b01});
      assign take       = (shifted >= trial);
      assign rem_in[k]  = take ? (shifted - trial) : shifted;
      assign root_in[k] = {root_prev[ROOT_W-2:0], take};
      assign rad_in[k]  = {rad_prev[2*ROOT_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < ROOT_W; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

### hdl/sscc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscc_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sscc_divider #(
   parameter int DEN_W = sscc_pkg::MAG_WIDTH,
   parameter int QUO_W = sscc_pkg::QUO_WIDTH
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [DEN_W+QUO_W-1:0] numer,
   input  logic [DEN_W-1:0]       denom,
   output logic [QUO_W-1:0]       quot
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [DEN_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] low_in [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];
   logic [DEN_W-1:0] den_in [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [QUO_W-1:0] low_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DEN_W:0]   shifted;
      logic [DEN_W:0]   diff;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev = numer[DEN_W+QUO_W-1:QUO_W];
         assign low_prev = numer[QUO_W-1:0];
         assign quo_prev = '0;
         assign den_prev = denom;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      assign shifted   = {rem_prev, low_prev[QUO_W-1]};
      assign take      = (shifted >= {1'b0, den_prev});
      assign diff      = shifted - {1'b0, den_prev};
      assign rem_in[k] = take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      assign low_in[k] = {low_prev[QUO_W-2:0], 1'b0};
      assign quo_in[k] = {quo_prev[QUO_W-2:0], take};
      assign den_in[k] = den_prev;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < QUO_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   end

   assign quot = quo_ff[QUO_W-1];

endmodule

### hdl/sphere_sphere_contact_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_sphere_contact_core
// Sphere pair contact test: squared distance, threshold compare, square
// root and six divisions give the two surface points of a touching pair.
//
//   channel  direction  word           handshake
//   req_     in         req_word_type  req_valid / req_stall
//   rsp_     out        rsp_word_type  rsp_valid / rsp_stall
//   csr_     in         csr_data       csr_write, csr_index
//
// one pair per cycle while no result word waits on rsp_stall. the square
// root works a bit per stage (COORD_WIDTH + 1 stages), as do the dividers
// (32 stages). pairs outside the threshold leave no word.
// synchronous reset clears valid bits and margins.
// the whole pipeline holds while a result word waits on rsp_stall.
// ----------------------------------------------------------------------------
module sphere_sphere_contact_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sscc_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sscc_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_write,
   input  logic [sscc_pkg::CSR_ADDR_WIDTH-1:0]   csr_index,
   input  logic [sscc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   import sscc_pkg::*;

   localparam int C  = COORD_WIDTH;
   localparam int H  = HALF_MAG;
   localparam int HT = HALF_THR;

   logic enable;
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // margins
   logic [LEN_WIDTH-1:0] margin_a_ff, margin_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_a_ff <= '0;
         margin_b_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MARGIN_A: margin_a_ff <= csr_data;
            REG_MARGIN_B: margin_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: input word
   req_word_type req_ff;
   logic         v1_ff;

   // stage 2: differences and thresholds
   logic [2:0][C-1:0]         ca2_ff, cb2_ff;
   logic [2:0]                neg2_ff;
   logic [MAG_WIDTH-1:0]      mag2_ff [3];
   logic [LEN_WIDTH-1:0]      ra2_ff, rb2_ff;
   logic [THR_WIDTH-1:0]      thr2_ff, rsum2_ff;
   logic                      fric2_ff;
   logic [INDEX_WIDTH-1:0]    ia2_ff, ib2_ff;
   logic                      v2_ff;

   logic [2:0][C-1:0]         ca_in, cb_in;
   logic [2:0]                neg_in;
   logic [MAG_WIDTH-1:0]      mag_in [3];
   logic [MAG_WIDTH-1:0]      diff_w [3];

   always_comb begin
      ca_in[0] = req_ff.centre_a_x;
      ca_in[1] = req_ff.centre_a_y;
      ca_in[2] = req_ff.centre_a_z;
      cb_in[0] = req_ff.centre_b_x;
      cb_in[1] = req_ff.centre_b_y;
      cb_in[2] = req_ff.centre_b_z;
      for (int i = 0; i < 3; i++) begin
         diff_w[i] = {cb_in[i][C-1], cb_in[i]} - {ca_in[i][C-1], ca_in[i]};
         neg_in[i] = diff_w[i][MAG_WIDTH-1];
         mag_in[i] = neg_in[i] ? (~diff_w[i] + 1'b1) : diff_w[i];
      end
   end

   // stage 3: partial products
   logic [2:0][C-1:0]         ca3_ff, cb3_ff;
   logic [2:0]                neg3_ff;
   logic [2*H-1:0]            mhh_ff [3], mhl_ff [3], mll_ff [3];
   logic [LEN_WIDTH+H-1:0]    pah_ff [3], pal_ff [3], pbh_ff [3], pbl_ff [3];
   logic [2*HT-1:0]           thh_ff, thl_ff, tll_ff, rhh_ff, rhl_ff, rll_ff;
   logic                      fric3_ff;
   logic [INDEX_WIDTH-1:0]    ia3_ff, ib3_ff;
   logic                      v3_ff;

   logic [2*H-1:0]            mag_ext [3];
   logic [2*HT-1:0]           thr_ext, rsum_ext;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_ext[i] = (2*H)'(mag2_ff[i]);
      end
      thr_ext  = (2*HT)'(thr2_ff);
      rsum_ext = (2*HT)'(rsum2_ff);
   end

   // stage 4: squares and products
   logic [2:0][C-1:0]         ca4_ff, cb4_ff;
   logic [2:0]                neg4_ff;
   logic [SUM_WIDTH-1:0]      sq4_ff [3];
   logic [PROD_WIDTH-1:0]     pa4_ff [3], pb4_ff [3];
   logic [THR_SQ_WIDTH-1:0]   thsq4_ff, rssq4_ff;
   logic                      fric4_ff;
   logic [INDEX_WIDTH-1:0]    ia4_ff, ib4_ff;
   logic                      v4_ff;

   // stage 5: squared distance
   logic [2:0][C-1:0]         ca5_ff, cb5_ff;
   logic [2:0]                neg5_ff;
   logic [SUM_WIDTH-1:0]      s5_ff;
   logic [PROD_WIDTH-1:0]     pa5_ff [3], pb5_ff [3];
   logic [THR_SQ_WIDTH-1:0]   thsq5_ff, rssq5_ff;
   logic                      fric5_ff;
   logic [INDEX_WIDTH-1:0]    ia5_ff, ib5_ff;
   logic                      v5_ff;

   // stage 6: detection
   logic [SUM_WIDTH-1:0]      s6_ff;
   root_side_type             side6_ff;
   logic                      v6_ff;
   logic                      hit_w, sep_w;

   assign hit_w = (CMP_WIDTH'(s5_ff) <= CMP_WIDTH'(thsq5_ff));
   assign sep_w = (CMP_WIDTH'(s5_ff) >= CMP_WIDTH'(rssq5_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff && hit_w;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         req_ff <= req_word;

         ca2_ff   <= ca_in;
         cb2_ff   <= cb_in;
         neg2_ff  <= neg_in;
         for (int i = 0; i < 3; i++) begin
            mag2_ff[i] <= mag_in[i];
         end
         ra2_ff   <= req_ff.radius_a;
         rb2_ff   <= req_ff.radius_b;
         thr2_ff  <= THR_WIDTH'(req_ff.radius_a) + THR_WIDTH'(req_ff.radius_b)
                   + THR_WIDTH'(margin_a_ff) + THR_WIDTH'(margin_b_ff);
         rsum2_ff <= THR_WIDTH'(req_ff.radius_a) + THR_WIDTH'(req_ff.radius_b);
         fric2_ff <= req_ff.friction_a & req_ff.friction_b;
         ia2_ff   <= req_ff.first_index;
         ib2_ff   <= req_ff.second_index;

         ca3_ff   <= ca2_ff;
         cb3_ff   <= cb2_ff;
         neg3_ff  <= neg2_ff;
         for (int i = 0; i < 3; i++) begin
            mhh_ff[i] <= mag_ext[i][2*H-1:H] * mag_ext[i][2*H-1:H];
            mhl_ff[i] <= mag_ext[i][2*H-1:H] * mag_ext[i][H-1:0];
            mll_ff[i] <= mag_ext[i][H-1:0] * mag_ext[i][H-1:0];
            pah_ff[i] <= ra2_ff * mag_ext[i][2*H-1:H];
            pal_ff[i] <= ra2_ff * mag_ext[i][H-1:0];
            pbh_ff[i] <= rb2_ff * mag_ext[i][2*H-1:H];
            pbl_ff[i] <= rb2_ff * mag_ext[i][H-1:0];
         end
         thh_ff   <= thr_ext[2*HT-1:HT] * thr_ext[2*HT-1:HT];
         thl_ff   <= thr_ext[2*HT-1:HT] * thr_ext[HT-1:0];
         tll_ff   <= thr_ext[HT-1:0] * thr_ext[HT-1:0];
         rhh_ff   <= rsum_ext[2*HT-1:HT] * rsum_ext[2*HT-1:HT];
         rhl_ff   <= rsum_ext[2*HT-1:HT] * rsum_ext[HT-1:0];
         rll_ff   <= rsum_ext[HT-1:0] * rsum_ext[HT-1:0];
         fric3_ff <= fric2_ff;
         ia3_ff   <= ia2_ff;
         ib3_ff   <= ib2_ff;

         ca4_ff   <= ca3_ff;
         cb4_ff   <= cb3_ff;
         neg4_ff  <= neg3_ff;
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= SUM_WIDTH'({mhh_ff[i], {(2*H){1'b0}}}
                       + {mhl_ff[i], {(H+1){1'b0}}} + mll_ff[i]);
            pa4_ff[i] <= PROD_WIDTH'({pah_ff[i], {H{1'b0}}} + pal_ff[i]);
            pb4_ff[i] <= PROD_WIDTH'({pbh_ff[i], {H{1'b0}}} + pbl_ff[i]);
         end
         thsq4_ff <= THR_SQ_WIDTH'({thh_ff, {(2*HT){1'b0}}}
                   + {thl_ff, {(HT+1){1'b0}}} + tll_ff);
         rssq4_ff <= THR_SQ_WIDTH'({rhh_ff, {(2*HT){1'b0}}}
                   + {rhl_ff, {(HT+1){1'b0}}} + rll_ff);
         fric4_ff <= fric3_ff;
         ia4_ff   <= ia3_ff;
         ib4_ff   <= ib3_ff;

         ca5_ff   <= ca4_ff;
         cb5_ff   <= cb4_ff;
         neg5_ff  <= neg4_ff;
         s5_ff    <= sq4_ff[0] + sq4_ff[1] + sq4_ff[2];
         for (int i = 0; i < 3; i++) begin
            pa5_ff[i] <= pa4_ff[i];
            pb5_ff[i] <= pb4_ff[i];
         end
         thsq5_ff <= thsq4_ff;
         rssq5_ff <= rssq4_ff;
         fric5_ff <= fric4_ff;
         ia5_ff   <= ia4_ff;
         ib5_ff   <= ib4_ff;

         s6_ff                <= s5_ff;
         side6_ff.ca          <= ca5_ff;
         side6_ff.cb          <= cb5_ff;
         side6_ff.neg         <= neg5_ff;
         for (int i = 0; i < 3; i++) begin
            side6_ff.prod_a[i] <= pa5_ff[i];
            side6_ff.prod_b[i] <= pb5_ff[i];
         end
         side6_ff.separated   <= sep_w;
         side6_ff.friction_on <= fric5_ff;
         side6_ff.idx_first   <= ia5_ff;
         side6_ff.idx_second  <= ib5_ff;
      end
   end

   // square root
   logic [MAG_WIDTH-1:0] dist_w;
   root_side_type        side_r;
   logic                 v_r;

   sscc_sqrt #(
      .ROOT_W (MAG_WIDTH)
   ) u_sqrt (
      .clock    (clock),
      .enable   (enable),
      .radicand (s6_ff),
      .root     (dist_w)
   );

   sscc_delay #(
      .WIDTH ($bits(root_side_type)),
      .DEPTH (MAG_WIDTH)
   ) u_root_delay (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v6_ff),
      .in_data   (side6_ff),
      .out_valid (v_r),
      .out_data  (side_r)
   );

   // stage 7: rounded numerators
   logic [PROD_WIDTH-1:0] na7_ff [3], nb7_ff [3];
   logic [MAG_WIDTH-1:0]  dist7_ff;
   quo_side_type          side7_ff;
   logic                  v7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (enable) begin
         v7_ff <= v_r;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            na7_ff[i] <= side_r.prod_a[i] + PROD_WIDTH'(dist_w >> 1);
            nb7_ff[i] <= side_r.prod_b[i] + PROD_WIDTH'(dist_w >> 1);
         end
         dist7_ff             <= dist_w;
         side7_ff.ca          <= side_r.ca;
         side7_ff.cb          <= side_r.cb;
         side7_ff.neg         <= side_r.neg;
         side7_ff.zero        <= (dist_w == '0);
         side7_ff.separated   <= side_r.separated;
         side7_ff.friction_on <= side_r.friction_on;
         side7_ff.idx_first   <= side_r.idx_first;
         side7_ff.idx_second  <= side_r.idx_second;
      end
   end

   // dividers
   logic [QUO_WIDTH-1:0] qa_w [3], qb_w [3];
   quo_side_type         side_q;
   logic                 v_q;

   for (genvar i = 0; i < 3; i++) begin : g_div
      sscc_divider #(
         .DEN_W (MAG_WIDTH),
         .QUO_W (QUO_WIDTH)
      ) u_div_a (
         .clock  (clock),
         .enable (enable),
         .numer  ({1'b0, na7_ff[i]}),
         .denom  (dist7_ff),
         .quot   (qa_w[i])
      );

      sscc_divider #(
         .DEN_W (MAG_WIDTH),
         .QUO_W (QUO_WIDTH)
      ) u_div_b (
         .clock  (clock),
         .enable (enable),
         .numer  ({1'b0, nb7_ff[i]}),
         .denom  (dist7_ff),
         .quot   (qb_w[i])
      );
   end

   sscc_delay #(
      .WIDTH ($bits(quo_side_type)),
      .DEPTH (QUO_WIDTH)
   ) u_quo_delay (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (v7_ff),
      .in_data   (side7_ff),
      .out_valid (v_q),
      .out_data  (side_q)
   );

   // final: offsets, saturation, result word
   localparam logic [EXT_WIDTH-1:0] PT_MAX = {{(EXT_WIDTH-C+1){1'b0}}, {(C-1){1'b1}}};
   localparam logic [EXT_WIDTH-1:0] PT_MIN = {{(EXT_WIDTH-C+1){1'b1}}, {(C-1){1'b0}}};

   logic signed [EXT_WIDTH-1:0] off_a [3], off_b [3], sum_a [3], sum_b [3];
   logic [2:0][C-1:0]           pt_a, pt_b;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_a[i] = side_q.zero ? '0 : $signed(EXT_WIDTH'(qa_w[i]));
         off_b[i] = side_q.zero ? '0 : $signed(EXT_WIDTH'(qb_w[i]));
         if (side_q.neg[i]) begin
            off_a[i] = -off_a[i];
            off_b[i] = -off_b[i];
         end
         sum_a[i] = $signed({{(EXT_WIDTH-C){side_q.ca[i][C-1]}}, side_q.ca[i]}) + off_a[i];
         sum_b[i] = $signed({{(EXT_WIDTH-C){side_q.cb[i][C-1]}}, side_q.cb[i]}) - off_b[i];
         if (sum_a[i] > $signed(PT_MAX)) begin
            pt_a[i] = PT_MAX[C-1:0];
         end else if (sum_a[i] < $signed(PT_MIN)) begin
            pt_a[i] = PT_MIN[C-1:0];
         end else begin
            pt_a[i] = sum_a[i][C-1:0];
         end
         if (sum_b[i] > $signed(PT_MAX)) begin
            pt_b[i] = PT_MAX[C-1:0];
         end else if (sum_b[i] < $signed(PT_MIN)) begin
            pt_b[i] = PT_MIN[C-1:0];
         end else begin
            pt_b[i] = sum_b[i][C-1:0];
         end
      end
   end

   rsp_word_type rsp_ff;
   logic         rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= v_q;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff.point_a_x            <= pt_a[0];
         rsp_ff.point_a_y            <= pt_a[1];
         rsp_ff.point_a_z            <= pt_a[2];
         rsp_ff.point_b_x            <= pt_b[0];
         rsp_ff.point_b_y            <= pt_b[1];
         rsp_ff.point_b_z            <= pt_b[2];
         rsp_ff.separated            <= side_q.separated;
         rsp_ff.friction_on          <= side_q.friction_on;
         rsp_ff.contact_first_index  <= side_q.idx_first;
         rsp_ff.contact_second_index <= side_q.idx_second;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no word waiting");

   a_pipe_frozen : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(v1_ff) && $stable(v6_ff) && $stable(v7_ff)))
      else $error("pipeline moved while output held");

   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !v1_ff && !v7_ff))
      else $error("valid bits not cleared by reset");

endmodule

### dv/sphere_sphere_contact_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_sphere_contact_core_tb
// Drives sphere pairs through the contact core under several margin settings
// and idle patterns, predicts each contact word in exact wide arithmetic and
// compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
module sphere_sphere_contact_core_tb;
   import sscc_pkg::*;

   localparam int  LATENCY     = 73;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  PHASE_ITEMS = 250;

   class contact_scoreboard;
      rsp_word_type           contacts_due[$];
      logic [LEN_WIDTH-1:0]   margin_a;
      logic [LEN_WIDTH-1:0]   margin_b;
      int                     errors;

      function new();
         margin_a = '0;
         margin_b = '0;
         errors   = 0;
      endfunction

      function void report(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endfunction

      function logic [63:0] floor_root(logic [127:0] s);
         logic [63:0]  r;
         logic [127:0] c;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c = {64'd0, r | (64'd1 << b)};
            if (c * c <= s) r = r | (64'd1 << b);
         end
         return r;
      endfunction

      function logic signed [127:0] offset(logic [63:0] rad, logic signed [63:0] d,
                                           logic [63:0] root_len);
         logic [127:0] mag;
         logic [127:0] q;
         if (root_len == 0) return 0;
         mag = d < 0 ? 128'(-d) : 128'(d);
         q = (128'(rad) * mag + 128'(root_len >> 1)) / 128'(root_len);
         return d < 0 ? -$signed(q) : $signed(q);
      endfunction

      function logic signed [COORD_WIDTH-1:0] saturate(logic signed [127:0] v);
         if (v > 128'sd2147483647) return 32'sh7fffffff;
         if (v < -128'sd2147483648) return 32'sh80000000;
         return v[COORD_WIDTH-1:0];
      endfunction

      function void note(req_word_type w);
         logic signed [63:0] a [3];
         logic signed [63:0] b [3];
         logic signed [63:0] d [3];
         logic [127:0]       s, mag;
         logic [127:0]       rsum, thr;
         logic [63:0]        root_len;
         rsp_word_type       c;
         a[0] = w.centre_a_x; a[1] = w.centre_a_y; a[2] = w.centre_a_z;
         b[0] = w.centre_b_x; b[1] = w.centre_b_y; b[2] = w.centre_b_z;
         s = '0;
         for (int i = 0; i < 3; i++) begin
            d[i] = b[i] - a[i];
            mag  = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
            s    = s + mag * mag;
         end
         rsum = 128'(w.radius_a) + 128'(w.radius_b);
         thr  = rsum + 128'(margin_a) + 128'(margin_b);
         if (s > thr * thr) return;
         root_len = floor_root(s);
         c.point_a_x = saturate(128'(a[0]) + offset(64'(w.radius_a), d[0], root_len));
         c.point_a_y = saturate(128'(a[1]) + offset(64'(w.radius_a), d[1], root_len));
         c.point_a_z = saturate(128'(a[2]) + offset(64'(w.radius_a), d[2], root_len));
         c.point_b_x = saturate(128'(b[0]) - offset(64'(w.radius_b), d[0], root_len));
         c.point_b_y = saturate(128'(b[1]) - offset(64'(w.radius_b), d[1], root_len));
         c.point_b_z = saturate(128'(b[2]) - offset(64'(w.radius_b), d[2], root_len));
         c.separated            = s >= rsum * rsum;
         c.friction_on          = w.friction_a & w.friction_b;
         c.contact_first_index  = w.first_index;
         c.contact_second_index = w.second_index;
         contacts_due = {contacts_due, c};
      endfunction

      function void field(string what, longint got, longint want);
         if (got != want) report(what, got, want);
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type want;
         if (contacts_due.size() == 0) begin
            report("unexpected contact word, point_a_x", got.point_a_x, 0);
            return;
         end
         want = contacts_due.pop_front();
         field("point_a_x", got.point_a_x, want.point_a_x);
         field("point_a_y", got.point_a_y, want.point_a_y);
         field("point_a_z", got.point_a_z, want.point_a_z);
         field("point_b_x", got.point_b_x, want.point_b_x);
         field("point_b_y", got.point_b_y, want.point_b_y);
         field("point_b_z", got.point_b_z, want.point_b_z);
         field("separated", got.separated, want.separated);
         field("friction_on", got.friction_on, want.friction_on);
         field("contact_first_index", got.contact_first_index, want.contact_first_index);
         field("contact_second_index", got.contact_second_index,
               want.contact_second_index);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_word_type              req_word;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_word_type              rsp_word;
   logic                      csr_write;
   logic [CSR_ADDR_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   contact_scoreboard sb = new();
   int  tx_idle;
   int  rx_idle;
   bit  want_hold;
   int  hold_left;
   int  cycles;

   sphere_sphere_contact_core dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("sphere_sphere_contact_core_tb failed");
         $finish;
      end
   end

   // receiver: random stall plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (want_hold) begin
         want_hold <= 1'b0;
         hold_left <= 600;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < rx_idle;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_word);
   end

   task automatic write_margin(logic [CSR_ADDR_WIDTH-1:0] idx, logic [LEN_WIDTH-1:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_MARGIN_A) sb.margin_a = v;
      else sb.margin_b = v;
   endtask

   task automatic send_pair(req_word_type w);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.contacts_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 30) @(posedge clock);
   endtask

   function automatic req_word_type pair_at(logic signed [31:0] ax, logic signed [31:0] ay,
                                            logic signed [31:0] az, logic signed [31:0] bx,
                                            logic signed [31:0] by, logic signed [31:0] bz,
                                            logic [31:0] ra, logic [31:0] rb);
      req_word_type w;
      w.centre_a_x = ax; w.centre_a_y = ay; w.centre_a_z = az;
      w.centre_b_x = bx; w.centre_b_y = by; w.centre_b_z = bz;
      w.radius_a = ra[LEN_WIDTH-1:0]; w.radius_b = rb[LEN_WIDTH-1:0];
      w.friction_a = 1'($urandom_range(1)); w.friction_b = 1'($urandom_range(1));
      w.first_index = INDEX_WIDTH'($urandom); w.second_index = INDEX_WIDTH'($urandom);
      return w;
   endfunction

   function automatic req_word_type random_pair();
      req_word_type w;
      int           r;
      w = ($bits(req_word_type))'({$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(99) < 80) begin
         // near pair with random content
         r = $urandom_range(24);
         w.centre_b_x = w.centre_a_x + $signed($urandom_range(2 << r)) - (1 << r);
         w.centre_b_y = w.centre_a_y + $signed($urandom_range(2 << r)) - (1 << r);
         w.centre_b_z = w.centre_a_z + $signed($urandom_range(2 << r)) - (1 << r);
         w.radius_a   = LEN_WIDTH'($urandom_range(2 << r));
         w.radius_b   = LEN_WIDTH'($urandom_range(2 << r));
      end
      return w;
   endfunction

   task automatic directed_pairs();
      req_word_type w;
      send_pair(pair_at(5, -7, 9, 5, -7, 9, 32'h10000, 32'h20000));
      send_pair(pair_at(0, 0, 0, 3 << 16, 4 << 16, 0, 2 << 16, 3 << 16));
      send_pair(pair_at(0, 0, 0, 3 << 16, 4 << 16, 0, 2 << 16, (3 << 16) + 1));
      send_pair(pair_at(0, 0, 0, 3 << 16, 4 << 16, 0, 2 << 16, (3 << 16) - 1));
      send_pair(pair_at(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'h7fffffff, 32'h7fffffff));
      send_pair(pair_at(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7ffffffe, 32'sh7fffffff, 32'sh7fffffff,
                        32'h7fffffff, 32'h7fffffff));
      send_pair(pair_at(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh80000001, 32'sh80000000, 32'sh80000000,
                        32'h7fffffff, 32'h7fffffff));
      send_pair(pair_at(-1, 1, -1, 1, -1, 1, 0, 0));
      send_pair(pair_at(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_at(100, 200, 300, -100, -200, -300, 32'h7fffffff, 0));
      for (int f = 0; f < 4; f++) begin
         w = pair_at(1 << 16, 2 << 16, 3 << 16, 2 << 16, 2 << 16, 3 << 16, 1 << 16, 1 << 16);
         w.friction_a   = f[0];
         w.friction_b   = f[1];
         w.first_index  = f[0] ? 16'hffff : 16'h0000;
         w.second_index = f[1] ? 16'h0000 : 16'hffff;
         send_pair(w);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      tx_idle   = 0;
      rx_idle   = 0;
      want_hold = 1'b0;
      cycles    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_margin(REG_MARGIN_A, '0);
      write_margin(REG_MARGIN_B, '0);
      directed_pairs();
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               tx_idle = 31; rx_idle = 51;
               write_margin(REG_MARGIN_A, LEN_WIDTH'($urandom_range(1 << 20)));
               write_margin(REG_MARGIN_B, LEN_WIDTH'($urandom_range(1 << 20)));
            end
            1: begin
               tx_idle = 51; rx_idle = 31;
               write_margin(REG_MARGIN_A, 31'h7fffffff);
               write_margin(REG_MARGIN_B, 31'h7fffffff);
            end
            2: begin
               tx_idle = 0; rx_idle = 0;
               write_margin(REG_MARGIN_A, LEN_WIDTH'($urandom));
               write_margin(REG_MARGIN_B, '0);
            end
            default: begin
               tx_idle = 0; rx_idle = 0;
               write_margin(REG_MARGIN_A, '0);
               write_margin(REG_MARGIN_B, 31'h7fffffff);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 20) want_hold <= 1'b1;
            send_pair(random_pair());
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("sphere_sphere_contact_core_tb passed");
      end else begin
         $display("sphere_sphere_contact_core_tb failed");
      end
      $finish;
   end

endmodule
